[hdl/assert_macros.svh]
// assertion macros used by the checker file pss_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rstn, expr) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("forbidden condition seen");

`endif

[hdl/pss_pkg.sv]
// types and constants for the pump sequencer with ramp
// no dependencies
package pss_pkg;

  localparam int unsigned LevelW = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [LevelW-1:0] LevelMax = 16'hFFFF;
  localparam logic [7:0]        DutyMax  = 8'd255;

  typedef enum logic [2:0] {
    MODE_INIT    = 3'd0,
    MODE_PRIME   = 3'd1,
    MODE_ARMED   = 3'd2,
    MODE_FLOW    = 3'd3,
    MODE_HOLDING = 3'd4,
    MODE_STOPPED = 3'd5
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PACK_THRESH  = 3'd0,
    CFG_HOLD_TIME_MS = 3'd1,
    CFG_PRIME_POWER  = 3'd2,
    CFG_FLOW_POWER   = 3'd3,
    CFG_RAMP_STEP    = 3'd4
  } cfg_idx_e;

  localparam logic [LevelW-1:0] RstPackThresh = 16'd80;
  localparam logic [TimeW-1:0]  RstHoldTimeMs = 32'd10000;
  localparam logic [LevelW-1:0] RstPrimePower = 16'd22000;
  localparam logic [LevelW-1:0] RstFlowPower  = 16'd11000;
  localparam logic [LevelW-1:0] RstRampStep   = 16'd100;

  typedef struct packed {
    logic [LevelW-1:0] pack_thresh;
    logic [TimeW-1:0]  hold_time_ms;
    logic [LevelW-1:0] prime_power;
    logic [LevelW-1:0] flow_power;
    logic [LevelW-1:0] ramp_step;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [LevelW-1:0] target_level;
    logic [LevelW-1:0] current_level;
    logic [TimeW-1:0]  hold_start_ms;
  } state_t;

endpackage

[hdl/pss_step.sv]
// next-state logic for one tick: mode step, ramp and pwm duty
// depends on pss_pkg
module pss_step import pss_pkg::*; (
  input  cfg_t              cfg_i,
  input  state_t            state_i,
  input  logic              obstruction_closed_i,
  input  logic [LevelW-1:0] pressure_i,
  input  logic [TimeW-1:0]  now_ms_i,
  output state_t            state_o,
  output logic [DutyW-1:0]  pwm_duty_o,
  output logic              task_complete_o
);

  logic              packed_w;
  logic [TimeW-1:0]  elapsed;
  state_t            seq;
  logic [LevelW:0]   up_sum;
  logic [LevelW-1:0] level_d;
  logic [23:0]       duty_prod;
  logic [7:0]        duty_q0;
  logic [LevelW:0]   duty_rem;

  assign packed_w = pressure_i >= cfg_i.pack_thresh;
  assign elapsed  = now_ms_i - state_i.hold_start_ms;

  always_comb begin
    seq             = state_i;
    task_complete_o = 1'b0;
    unique case (state_i.mode)
      MODE_INIT: begin
        seq.mode = obstruction_closed_i ? MODE_ARMED : MODE_PRIME;
      end
      MODE_PRIME: begin
        seq.target_level = cfg_i.prime_power;
        if (obstruction_closed_i) begin
          seq.mode = MODE_ARMED;
        end
      end
      MODE_ARMED: begin
        seq.target_level = '0;
        if (!obstruction_closed_i) begin
          seq.mode = MODE_FLOW;
        end
      end
      MODE_FLOW: begin
        seq.target_level = cfg_i.flow_power;
        if (packed_w) begin
          seq.mode          = MODE_HOLDING;
          seq.hold_start_ms = now_ms_i;
        end
      end
      MODE_HOLDING: begin
        seq.target_level = cfg_i.flow_power;
        if (!packed_w) begin
          seq.mode = MODE_FLOW;
        end else if (elapsed >= cfg_i.hold_time_ms) begin
          seq.mode = MODE_STOPPED;
        end
      end
      MODE_STOPPED: begin
        seq.target_level = '0;
        task_complete_o  = 1'b1;
        if (obstruction_closed_i) begin
          seq.mode = MODE_ARMED;
        end
      end
      default: begin
        seq = state_i;
      end
    endcase
  end

  // ramp toward target, saturating at both ends
  assign up_sum = {1'b0, state_i.current_level} + {1'b0, cfg_i.ramp_step};

  always_comb begin
    priority if (seq.target_level > state_i.current_level) begin
      level_d = up_sum[LevelW] ? LevelMax : up_sum[LevelW-1:0];
    end else if (seq.target_level < state_i.current_level) begin
      level_d = (state_i.current_level > cfg_i.ramp_step) ?
                (state_i.current_level - cfg_i.ramp_step) : '0;
    end else begin
      level_d = state_i.current_level;
    end
  end

  always_comb begin
    state_o               = seq;
    state_o.current_level = level_d;
  end

  // level*255/65535: estimate by >>16, then one correction step
  assign duty_prod  = {8'd0, level_d} * {16'd0, DutyMax};
  assign duty_q0    = duty_prod[23:16];
  assign duty_rem   = {1'b0, duty_prod[15:0]} + {9'd0, duty_q0};
  assign pwm_duty_o = (duty_rem >= {1'b0, LevelMax}) ? (duty_q0 + 8'd1) : duty_q0;

endmodule

[hdl/pump_sequencer_with_ramp.sv]
// top level of the pump sequencer with drive-level ramp
// depends on pss_pkg and pss_step
//
// One input transaction is one control tick and yields exactly one result
// transaction. The tick is worked out combinationally and the result lands
// in an output register, so results appear in the cycle after acceptance
// and a new tick is accepted every cycle while the output register is empty
// or being drained. Throughput is one transaction per cycle, set by the
// single output register: when the consumer stalls, input stalls with it.
// Configuration writes take effect at the next clock edge.
module pump_sequencer_with_ramp import pss_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                obstruction_closed_i,
  input  logic [LevelW-1:0]   pressure_i,
  input  logic [TimeW-1:0]    now_ms_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [LevelW-1:0]   drive_level_o,
  output logic [DutyW-1:0]    pwm_duty_o,
  output logic                task_complete_o,
  output logic [2:0]          mode_o
);

  cfg_t              cfg_q;
  state_t            state_q, state_d;
  logic              in_acc;
  logic              out_valid_q;
  logic [LevelW-1:0] drive_level_q;
  logic [DutyW-1:0]  pwm_duty_q, pwm_duty_d;
  logic              task_complete_q, task_complete_d;
  logic [2:0]        mode_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pack_thresh  <= RstPackThresh;
      cfg_q.hold_time_ms <= RstHoldTimeMs;
      cfg_q.prime_power  <= RstPrimePower;
      cfg_q.flow_power   <= RstFlowPower;
      cfg_q.ramp_step    <= RstRampStep;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PACK_THRESH:  cfg_q.pack_thresh  <= cfg_wdata_i[LevelW-1:0];
        CFG_HOLD_TIME_MS: cfg_q.hold_time_ms <= cfg_wdata_i[TimeW-1:0];
        CFG_PRIME_POWER:  cfg_q.prime_power  <= cfg_wdata_i[LevelW-1:0];
        CFG_FLOW_POWER:   cfg_q.flow_power   <= cfg_wdata_i[LevelW-1:0];
        CFG_RAMP_STEP:    cfg_q.ramp_step    <= cfg_wdata_i[LevelW-1:0];
        default: begin
        end
      endcase
    end
  end

  pss_step u_step (
    .cfg_i                (cfg_q),
    .state_i              (state_q),
    .obstruction_closed_i (obstruction_closed_i),
    .pressure_i           (pressure_i),
    .now_ms_i             (now_ms_i),
    .state_o              (state_d),
    .pwm_duty_o           (pwm_duty_d),
    .task_complete_o      (task_complete_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode          <= MODE_INIT;
      state_q.target_level  <= '0;
      state_q.current_level <= '0;
      state_q.hold_start_ms <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      drive_level_q   <= state_d.current_level;
      pwm_duty_q      <= pwm_duty_d;
      task_complete_q <= task_complete_d;
      mode_q          <= state_d.mode;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_level_o   = drive_level_q;
  assign pwm_duty_o      = pwm_duty_q;
  assign task_complete_o = task_complete_q;
  assign mode_o          = mode_q;

endmodule

[hdl/pss_checker.sv]
// port-level checks for pump_sequencer_with_ramp, bound to the top level
// depends on pss_pkg and assert_macros.svh
`include "assert_macros.svh"

module pss_port_checks import pss_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [LevelW-1:0] drive_level_i,
  input logic [DutyW-1:0]  pwm_duty_i,
  input logic              task_complete_i,
  input logic [2:0]        mode_i
);

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  `ASSERT_CLK(a_out_held, clk_i, rst_ni,
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(drive_level_i)))
  `ASSERT_CLK(a_in_gives_out, clk_i, rst_ni, in_acc |=> out_valid_i)
  `ASSERT_CLK(a_drain_empties, clk_i, rst_ni, (out_acc && !in_acc) |=> !out_valid_i)
  `ASSERT_NEVER(a_done_mode, clk_i, rst_ni,
    out_valid_i && task_complete_i && (mode_i != MODE_STOPPED) && (mode_i != MODE_ARMED))
  `ASSERT_NEVER(a_duty_full, clk_i, rst_ni,
    out_valid_i && ((pwm_duty_i == DutyMax) != (drive_level_i == LevelMax)))

endmodule

bind pump_sequencer_with_ramp pss_port_checks u_pss_port_checks (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_i      (in_ready_o),
  .out_valid_i     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .drive_level_i   (drive_level_o),
  .pwm_duty_i      (pwm_duty_o),
  .task_complete_i (task_complete_o),
  .mode_i          (mode_o)
);
